FILE: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants for the max priority queue
// Record layout, sizing constants, command codes and sequencer states.
// ----------------------------------------------------------------------------
package mpq_pkg;

	// Queue sizing
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int CH_W     = IDX_W + 2;

	// Field widths
	localparam int ROLL_W  = 16;
	localparam int MARKS_W = 10;
	localparam int TAG_W   = 16;

	// One stored record
	typedef struct packed {
		logic [ROLL_W-1:0]  roll;
		logic [MARKS_W-1:0] marks;
		logic [TAG_W-1:0]   tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Command codes
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_PEEK   = 2'd1,
		CMD_POP    = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_LAST,
		ST_DN_GET,
		ST_DN_RDL,
		ST_DN_RDR,
		ST_DN_CMP,
		ST_RPT
	} state_t;

endpackage

FILE: rtl/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/mpq_rank.sv
// ----------------------------------------------------------------------------
// mpq_rank: record ranking compare
// True when record a ranks strictly above record b: larger marks first,
// then smaller roll, then smaller tag.
// ----------------------------------------------------------------------------
module mpq_rank (
	input  mpq_pkg::rec_t a,
	input  mpq_pkg::rec_t b,
	output logic          above
);
	import mpq_pkg::*;

	logic marks_gt;
	logic marks_eq;
	logic roll_lt;
	logic roll_eq;
	logic tag_lt;

	// field compares
	assign marks_gt = a.marks > b.marks;
	assign marks_eq = a.marks == b.marks;
	assign roll_lt  = a.roll < b.roll;
	assign roll_eq  = a.roll == b.roll;
	assign tag_lt   = a.tag < b.tag;

	// lexicographic rank
	assign above = marks_gt || (marks_eq && (roll_lt || (roll_eq && tag_lt)));

endmodule

FILE: rtl/max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_priority_queue_top: bounded max priority queue of records
// Binary max-heap in a single-port-read RAM, sifted by a small sequencer
// around one shared record compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and the in_* fields and raise start; the word
//   is taken at a clock edge where start is high and busy is low.
//   cmd: insert, peek (report top) or pop; the unused code acts as peek.
//   Result channel: done pulses for one cycle with is_empty, top_* and
//   dropped. The receiver cannot stall; each result must be taken as shown.
// Sequence (accept edge to done cycle):
//   peek, pop of the last record, refused insert: report state, then done.
//   insert: UP_CHK fetches the parent and UP_CMP ranks it, once per level
//   climbed; UP_CHK writes the record itself when it reaches the root.
//   pop: DN_LAST and DN_GET fetch the last record, then DN_RDL, DN_RDR and
//   DN_CMP per level; the record settles in DN_RDL at a leaf, else DN_CMP.
//   Each heap level needs one or two RAM reads through the single registered
//   read port and one or two compares in the shared rank unit.
// Throughput: one command at a time; busy is low again in the done cycle,
//   so the next command may be taken while a result is shown.
// Reset: the queue is empty; the record store needs no clearing pass.
// ----------------------------------------------------------------------------
module max_priority_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [mpq_pkg::ROLL_W-1:0]    in_roll,
	input  logic [mpq_pkg::MARKS_W-1:0]   in_marks,
	input  logic [mpq_pkg::TAG_W-1:0]     in_tag,
	output logic                          done,
	output logic                          is_empty,
	output logic [mpq_pkg::ROLL_W-1:0]    top_roll,
	output logic [mpq_pkg::MARKS_W-1:0]   top_marks,
	output logic [mpq_pkg::TAG_W-1:0]     top_tag,
	output logic                          dropped
);
	import mpq_pkg::*;

	// control state
	state_t           state_q, state_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic             done_q, done_d;

	// datapath state
	logic [IDX_W-1:0] i_q, i_d;
	rec_t             rec_q, rec_d;
	rec_t             best_q, best_d;
	rec_t             top_q, top_d;
	logic             lwin_q, lwin_d;
	logic             rok_q, rok_d;
	logic             drop_q, drop_d;
	logic             empty_q;
	rec_t             out_q;

	// RAM port
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	rec_t             ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [REC_W-1:0] ram_rdata;
	rec_t             rd_rec;

	// shared compare
	rec_t             cmp_a;
	rec_t             cmp_b;
	logic             cmp_above;

	// heap index arithmetic
	logic [IDX_W-1:0] i_m1;
	logic [IDX_W-1:0] pidx;
	logic [CH_W-1:0]  l_w;
	logic [CH_W-1:0]  r_w;
	logic [CH_W-1:0]  occ_ext;
	logic             accept;

	assign accept  = start && (state_q == ST_IDLE);
	assign i_m1    = i_q - 1'b1;
	assign pidx    = {1'b0, i_m1[IDX_W-1:1]};
	assign l_w     = {1'b0, i_q, 1'b1};
	assign r_w     = l_w + 1'b1;
	assign occ_ext = CH_W'(occ_q);
	assign rd_rec  = rec_t'(ram_rdata);

	mpq_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mpq_rank u_rank (
		.a    (cmp_a),
		.b    (cmp_b),
		.above(cmp_above)
	);

	// sequencer: next state, RAM control, compare operand select
	always_comb begin
		state_d   = state_q;
		occ_d     = occ_q;
		done_d    = 1'b0;
		i_d       = i_q;
		rec_d     = rec_q;
		best_d    = best_q;
		top_d     = top_q;
		lwin_d    = lwin_q;
		rok_d     = rok_q;
		drop_d    = drop_q;
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = rec_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		cmp_a     = rec_q;
		cmp_b     = rd_rec;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					drop_d  = 1'b0;
					state_d = ST_RPT;
					if (cmd == CMD_INSERT) begin
						if (occ_q == OCC_W'(CAPACITY)) begin
							drop_d = 1'b1;
						end else begin
							rec_d   = '{roll: in_roll, marks: in_marks, tag: in_tag};
							i_d     = occ_q[IDX_W-1:0];
							occ_d   = occ_q + 1'b1;
							state_d = ST_UP_CHK;
						end
					end else if (cmd == CMD_POP) begin
						if (occ_q != '0) begin
							occ_d = occ_q - 1'b1;
							if (occ_q != OCC_W'(1)) begin
								state_d = ST_DN_LAST;
							end
						end
					end
				end
			end

			// sift up: hole at i, fetch parent or settle at root
			ST_UP_CHK: begin
				if (i_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					top_d     = rec_q;
					state_d   = ST_RPT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = pidx;
					state_d   = ST_UP_CMP;
				end
			end

			// sift up: move parent down or place the new record
			ST_UP_CMP: begin
				cmp_a  = rec_q;
				cmp_b  = rd_rec;
				ram_we = 1'b1;
				if (cmp_above) begin
					ram_wdata = rd_rec;
					i_d       = pidx;
					state_d   = ST_UP_CHK;
				end else begin
					state_d = ST_RPT;
				end
			end

			// sift down: fetch the last record, it fills the root hole
			ST_DN_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = occ_q[IDX_W-1:0];
				state_d   = ST_DN_GET;
			end

			ST_DN_GET: begin
				rec_d   = rd_rec;
				i_d     = '0;
				state_d = ST_DN_RDL;
			end

			// sift down: fetch left child or settle
			ST_DN_RDL: begin
				if (l_w < occ_ext) begin
					ram_re    = 1'b1;
					ram_raddr = l_w[IDX_W-1:0];
					state_d   = ST_DN_RDR;
				end else begin
					ram_we  = 1'b1;
					if (i_q == '0) begin
						top_d = rec_q;
					end
					state_d = ST_RPT;
				end
			end

			// sift down: rank left child against the moving record, fetch right
			ST_DN_RDR: begin
				cmp_a  = rd_rec;
				cmp_b  = rec_q;
				lwin_d = cmp_above;
				best_d = cmp_above ? rd_rec : rec_q;
				rok_d  = r_w < occ_ext;
				if (r_w < occ_ext) begin
					ram_re    = 1'b1;
					ram_raddr = r_w[IDX_W-1:0];
				end
				state_d = ST_DN_CMP;
			end

			// sift down: pick the winner and move it into the hole
			ST_DN_CMP: begin
				cmp_a  = rd_rec;
				cmp_b  = best_q;
				ram_we = 1'b1;
				if (rok_q && cmp_above) begin
					ram_wdata = rd_rec;
					i_d       = r_w[IDX_W-1:0];
					state_d   = ST_DN_RDL;
				end else if (lwin_q) begin
					ram_wdata = best_q;
					i_d       = l_w[IDX_W-1:0];
					state_d   = ST_DN_RDL;
				end else begin
					state_d = ST_RPT;
				end
				if (i_q == '0) begin
					top_d = ram_wdata;
				end
			end

			ST_RPT: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			done_q  <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		i_q    <= i_d;
		rec_q  <= rec_d;
		best_q <= best_d;
		top_q  <= top_d;
		lwin_q <= lwin_d;
		rok_q  <= rok_d;
		drop_q <= drop_d;
	end

	// result word, loaded in the report cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_RPT) begin
			empty_q <= (occ_q == '0);
			out_q   <= (occ_q == '0) ? '0 : top_q;
			dropped <= drop_q;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign is_empty  = empty_q;
	assign top_roll  = out_q.roll;
	assign top_marks = out_q.marks;
	assign top_tag   = out_q.tag;

	// occupancy never exceeds the store
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("occupancy above capacity");

	// an insert with room grows the queue by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_INSERT && occ_q != OCC_W'(CAPACITY))
		|=> occ_q == $past(occ_q) + 1'b1)
		else $error("insert did not grow occupancy");

	// the report cycle is always followed by the strobe
	a_rpt_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RPT |=> done_q)
		else $error("report without strobe");

	// empty flag agrees with occupancy when shown
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (is_empty == (occ_q == '0)))
		else $error("empty flag mismatch");

	// the store is never written while idle
	a_idle_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we)
		else $error("store write while idle");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for max_priority_queue_top
// Sends insert, peek, pop and spare-code words through the start/busy port.
// Keeps its own max-heap of records to work out the top record, empty flag
// and drop flag for every accepted word. Each done strobe is checked field
// by field against the oldest pending prediction. Runs directed corners,
// fill-to-full and drain, and random traffic with varied idle on start.
// ----------------------------------------------------------------------------
module tb_top;
	import mpq_pkg::*;

	localparam int RUN_LIMIT   = 400000;
	localparam int SETTLE_CYC  = 32;
	localparam int SHOW_FAULTS = 10;

	// One reported top word
	typedef struct packed {
		logic               is_empty;
		logic [ROLL_W-1:0]  roll;
		logic [MARKS_W-1:0] marks;
		logic [TAG_W-1:0]   tag;
		logic               dropped;
	} top_word_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          cmd;
	logic [ROLL_W-1:0]   in_roll;
	logic [MARKS_W-1:0]  in_marks;
	logic [TAG_W-1:0]    in_tag;
	logic                done;
	logic                is_empty;
	logic [ROLL_W-1:0]   top_roll;
	logic [MARKS_W-1:0]  top_marks;
	logic [TAG_W-1:0]    top_tag;
	logic                dropped;

	// Predicted heap and pending top words
	rec_t        heap_mem [CAPACITY];
	int unsigned heap_cnt = 0;
	top_word_t   top_expected [$];

	int unsigned fault_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned idle_pct  = 0;

	max_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.in_roll   (in_roll),
		.in_marks  (in_marks),
		.in_tag    (in_tag),
		.done      (done),
		.is_empty  (is_empty),
		.top_roll  (top_roll),
		.top_marks (top_marks),
		.top_tag   (top_tag),
		.dropped   (dropped)
	);

	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycle_cnt,
				top_expected.size());
			$display("** max_priority_queue_top: FAILED **");
			$finish;
		end
	end

	// Rank: larger marks, then smaller roll, then smaller tag
	function automatic bit outranks(rec_t a, rec_t b);
		if (a.marks != b.marks) return a.marks > b.marks;
		if (a.roll != b.roll) return a.roll < b.roll;
		return a.tag < b.tag;
	endfunction

	function automatic void heap_swap(int unsigned i, int unsigned j);
		rec_t t;
		t = heap_mem[i];
		heap_mem[i] = heap_mem[j];
		heap_mem[j] = t;
	endfunction

	// Apply one command to the heap and return the top word it reports
	function automatic top_word_t queue_apply(cmd_t op, rec_t r);
		top_word_t   w;
		int unsigned i, l, rt, best;
		bit          settled;
		w = '0;
		case (op)
			CMD_INSERT: begin
				if (heap_cnt >= CAPACITY) begin
					w.dropped = 1'b1;
				end else begin
					heap_mem[heap_cnt] = r;
					i = heap_cnt;
					heap_cnt++;
					while (i > 0 && outranks(heap_mem[i], heap_mem[(i - 1) / 2])) begin
						heap_swap(i, (i - 1) / 2);
						i = (i - 1) / 2;
					end
				end
			end
			CMD_POP: begin
				if (heap_cnt > 0) begin
					heap_cnt--;
					heap_mem[0] = heap_mem[heap_cnt];
					i = 0;
					settled = 1'b0;
					while (!settled) begin
						l = 2 * i + 1;
						rt = l + 1;
						best = i;
						if (l < heap_cnt && outranks(heap_mem[l], heap_mem[best])) best = l;
						if (rt < heap_cnt && outranks(heap_mem[rt], heap_mem[best])) best = rt;
						if (best == i) begin
							settled = 1'b1;
						end else begin
							heap_swap(i, best);
							i = best;
						end
					end
				end
			end
			default: ;
		endcase
		if (heap_cnt == 0) begin
			w.is_empty = 1'b1;
		end else begin
			w.roll  = heap_mem[0].roll;
			w.marks = heap_mem[0].marks;
			w.tag   = heap_mem[0].tag;
		end
		return w;
	endfunction

	function automatic void note_fault(string what, top_word_t want, top_word_t got);
		fault_cnt++;
		if (fault_cnt <= SHOW_FAULTS) begin
			$write("[%0t] %s: exp empty=%0b roll=%h marks=%0d tag=%h drop=%0b,",
				$time, what, want.is_empty, want.roll, want.marks, want.tag,
				want.dropped);
			$display(" got empty=%0b roll=%h marks=%0d tag=%h drop=%0b",
				got.is_empty, got.roll, got.marks, got.tag, got.dropped);
		end
	endfunction

	// Result checker: done is a one-cycle strobe, taken at the edge ending it
	always @(posedge clk) begin : result_chk
		top_word_t got, want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			got = {is_empty, top_roll, top_marks, top_tag, dropped};
			if (top_expected.size() == 0) begin
				note_fault("result with no word pending", '0, got);
			end else begin
				want = top_expected.pop_front();
				if (done !== 1'b1 || got.is_empty !== want.is_empty
						|| got.roll !== want.roll || got.marks !== want.marks
						|| got.tag !== want.tag || got.dropped !== want.dropped)
					note_fault("top word mismatch", want, got);
			end
		end
	end

	// Drive one word and hold it until taken; start is left high
	task automatic send_word(cmd_t op, rec_t r);
		start    <= 1'b1;
		cmd      <= op;
		in_roll  <= r.roll;
		in_marks <= r.marks;
		in_tag   <= r.tag;
		do @(posedge clk); while (busy !== 1'b0);
		top_expected.push_back(queue_apply(op, r));
	endtask

	// Random idle cycles on start, with junk on the fields meanwhile
	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			cmd      <= 2'($urandom_range(3));
			in_roll  <= ROLL_W'($urandom_range((1 << ROLL_W) - 1));
			in_marks <= MARKS_W'($urandom_range((1 << MARKS_W) - 1));
			in_tag   <= TAG_W'($urandom_range((1 << TAG_W) - 1));
			@(posedge clk);
		end
	endtask

	function automatic rec_t make_rec(int unsigned roll, int unsigned marks, int unsigned tag);
		rec_t r;
		r.roll  = ROLL_W'(roll);
		r.marks = MARKS_W'(marks);
		r.tag   = TAG_W'(tag);
		return r;
	endfunction

	// Random record; narrow ranges often, so that ties on keys are common
	function automatic rec_t rand_rec();
		rec_t r;
		r.marks = MARKS_W'(($urandom_range(1) != 0) ? $urandom_range(3)
		                                   : $urandom_range((1 << MARKS_W) - 1));
		r.roll  = ROLL_W'(($urandom_range(2) == 0) ? $urandom_range(3)
		                                   : $urandom_range((1 << ROLL_W) - 1));
		r.tag   = TAG_W'(($urandom_range(2) == 0) ? $urandom_range(1)
		                                   : $urandom_range((1 << TAG_W) - 1));
		return r;
	endfunction

	// Empty queue cases, key extremes, tie-breaks, pop down past empty
	task automatic test_corners();
		rec_t junk;
		junk = make_rec(16'hFFFF, 10'h3FF, 16'hFFFF);
		idle_pct = 0;
		send_word(CMD_PEEK, junk);
		send_word(CMD_POP, junk);
		send_word(CMD_RSVD, junk);
		send_word(CMD_INSERT, make_rec(16'h1234, 0, 16'hFFFF));
		send_word(CMD_INSERT, make_rec(16'hFFFF, 1023, 16'h0000));
		// equal marks: smaller roll wins
		send_word(CMD_INSERT, make_rec(16'h0000, 1023, 16'hFFFF));
		// equal marks and roll: smaller tag wins
		send_word(CMD_INSERT, make_rec(16'h0000, 1023, 16'h0001));
		// fully equal record
		send_word(CMD_INSERT, make_rec(16'h0000, 1023, 16'h0001));
		send_word(CMD_PEEK, junk);
		send_word(CMD_RSVD, junk);
		send_word(CMD_INSERT, make_rec(16'h0000, 1023, 16'h0000));
		send_word(CMD_INSERT, make_rec(16'h5555, 512, 16'hAAAA));
		send_word(CMD_INSERT, make_rec(16'hAAAA, 511, 16'h5555));
		// eight records held: the last pop reports empty, then pop on empty
		repeat (9) send_word(CMD_POP, junk);
		send_word(CMD_PEEK, junk);
	endtask

	// Fill to capacity, refused inserts, then drain to empty
	task automatic test_fill_drain();
		idle_pct = 0;
		repeat (CAPACITY) send_word(CMD_INSERT, rand_rec());
		repeat (3) send_word(CMD_INSERT, rand_rec());
		send_word(CMD_PEEK, rand_rec());
		repeat (CAPACITY + 1) send_word(CMD_POP, rand_rec());
	endtask

	// Random traffic; insert share changes every 50 words so occupancy
	// wanders between empty and full
	task automatic test_random(int unsigned n_words, int unsigned pct);
		int unsigned ins_w, pick;
		cmd_t        op;
		ins_w = 50;
		idle_pct = pct;
		for (int unsigned k = 0; k < n_words; k++) begin
			if (k % 50 == 0) begin
				case ($urandom_range(2))
					0: ins_w = 15;
					1: ins_w = 50;
					default: ins_w = 85;
				endcase
			end
			pick = $urandom_range(99);
			if (pick < ins_w) op = CMD_INSERT;
			else begin
				pick = $urandom_range(9);
				op = (pick < 7) ? CMD_POP : (pick < 9) ? CMD_PEEK : CMD_RSVD;
			end
			idle_gap();
			send_word(op, rand_rec());
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		cmd      <= CMD_PEEK;
		in_roll  <= '0;
		in_marks <= '0;
		in_tag   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_fill_drain();
		test_random(370, 0);
		test_random(370, 80);
		test_random(370, 25);

		// Drain, then let any stray strobe show up
		start <= 1'b0;
		while (top_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		if (fault_cnt == 0) begin
			$display("** max_priority_queue_top: PASSED **");
		end else begin
			$display("** max_priority_queue_top: FAILED **");
		end
		$finish;
	end

endmodule
